// ===== hw/rtl/rgbb_pkg.sv =====
// shared types and constants for the rgb565 to 24-bit bmp stream encoder
package rgbb_pkg;

    // largest image dimension that the counters and clamp support
    localparam int MAX_DIM = 4096;

    // configuration register widths and indexes
    localparam int CFG_W   = 13;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = 13'd320;
    localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 13'd180;

    // position counters and their compare width
    localparam int CNT_W = $clog2(MAX_DIM);
    localparam int CMP_W = (CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W;

    // row length in bytes and total pixel data size
    localparam int RB_W  = CFG_W + 2;
    localparam int IMG_W = RB_W + CFG_W;

    // header layout
    localparam int HDR_BYTES = 54;
    localparam int HCNT_W    = $clog2(HDR_BYTES);
    localparam logic [7:0] HDR_INFO_SIZE = 8'd40;
    localparam logic [7:0] HDR_PLANES    = 8'd1;
    localparam logic [7:0] HDR_BPP       = 8'd24;
    localparam logic [7:0] CHAR_B        = 8'h42;
    localparam logic [7:0] CHAR_M        = 8'h4D;

    // queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // one classified pixel, as handed from front to back
    typedef struct packed {
        logic             hdr;
        logic             eof;
        logic [1:0]       pad;
        logic [7:0]       blu;
        logic [7:0]       grn;
        logic [7:0]       red;
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
        logic [IMG_W-1:0] img_size;
    } t_cmd;

    // queue status
    typedef struct packed {
        logic          empty;
        logic          full;
        logic [Q_AW:0] level;
    } t_qstat;

    // back-end sequencer phases
    typedef enum logic [1:0] {
        PH_HDR,
        PH_PIX,
        PH_PAD
    } t_phase;

endpackage

// ===== hw/rtl/rgbb_front.sv =====
// front end: configuration registers, pixel acceptance and classification
module rgbb_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rgbb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rgbb_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_pixel_valid,
    output logic                          o_pixel_ready,
    input  logic [15:0]                   i_pixel,
    input  logic                          i_q_full,
    output logic                          o_push,
    output rgbb_pkg::t_cmd                o_cmd
);

    logic [rgbb_pkg::CFG_W-1:0] r_width;
    logic [rgbb_pkg::CFG_W-1:0] r_height;
    logic [rgbb_pkg::CNT_W-1:0] r_col;
    logic [rgbb_pkg::CNT_W-1:0] r_row;
    logic                       r_hdr_done;
    logic [rgbb_pkg::CNT_W-1:0] n_col;
    logic [rgbb_pkg::CNT_W-1:0] n_row;
    logic                       n_hdr_done;

    logic [rgbb_pkg::CFG_W-1:0] w_cl;
    logic [rgbb_pkg::CFG_W-1:0] h_cl;
    logic [rgbb_pkg::RB_W-1:0]  row_bytes;
    logic                       row_end;
    logic                       file_end;
    logic                       accept;

    // 5-bit channel to 8 bits, truncating v*255/31 = 8v + floor(7v/31)
    function automatic logic [7:0] expand5(input logic [4:0] v);
        logic [2:0] frac;
        begin
            frac = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
                 + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v == 5'd31);
            expand5 = {v, 3'b000} + 8'(frac);
        end
    endfunction

    // 6-bit channel to 8 bits, truncating v*255/63 = 4v + floor(v/21)
    function automatic logic [7:0] expand6(input logic [5:0] v);
        logic [1:0] frac;
        begin
            frac = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v == 6'd63);
            expand6 = {v, 2'b00} + 8'(frac);
        end
    endfunction

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= rgbb_pkg::RST_IMAGE_WIDTH;
            r_height <= rgbb_pkg::RST_IMAGE_HEIGHT;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == rgbb_pkg::CFG_IMAGE_WIDTH) begin
                r_width <= i_cfg_data;
            end
            if (i_cfg_idx == rgbb_pkg::CFG_IMAGE_HEIGHT) begin
                r_height <= i_cfg_data;
            end
        end
    end

    // dimension clamp to 1..MAX_DIM
    always_comb begin
        if (r_width == '0) begin
            w_cl = rgbb_pkg::CFG_W'(1);
        end else if (32'(r_width) > rgbb_pkg::MAX_DIM) begin
            w_cl = rgbb_pkg::CFG_W'(rgbb_pkg::MAX_DIM);
        end else begin
            w_cl = r_width;
        end
        if (r_height == '0) begin
            h_cl = rgbb_pkg::CFG_W'(1);
        end else if (32'(r_height) > rgbb_pkg::MAX_DIM) begin
            h_cl = rgbb_pkg::CFG_W'(rgbb_pkg::MAX_DIM);
        end else begin
            h_cl = r_height;
        end
    end

    // row padding equals width mod 4, row bytes is 3w plus padding
    assign row_bytes = {1'b0, w_cl, 1'b0} + rgbb_pkg::RB_W'(w_cl)
                     + rgbb_pkg::RB_W'(w_cl[1:0]);

    // row and file end
    assign row_end  = (rgbb_pkg::CMP_W'(r_col) + rgbb_pkg::CMP_W'(1))
                      >= rgbb_pkg::CMP_W'(w_cl);
    assign file_end = row_end && ((rgbb_pkg::CMP_W'(r_row) + rgbb_pkg::CMP_W'(1))
                      >= rgbb_pkg::CMP_W'(h_cl));

    assign o_pixel_ready = !i_q_full;
    assign accept        = i_pixel_valid && o_pixel_ready;
    assign o_push        = accept;

    // command word for the back end
    always_comb begin
        o_cmd.hdr      = !r_hdr_done;
        o_cmd.eof      = file_end;
        o_cmd.pad      = row_end ? w_cl[1:0] : 2'd0;
        o_cmd.blu      = expand5(i_pixel[4:0]);
        o_cmd.grn      = expand6(i_pixel[10:5]);
        o_cmd.red      = expand5(i_pixel[15:11]);
        o_cmd.width    = w_cl;
        o_cmd.height   = h_cl;
        o_cmd.img_size = row_bytes * rgbb_pkg::IMG_W'(h_cl);
    end

    // position tracking
    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_hdr_done = r_hdr_done;
        if (accept) begin
            n_hdr_done = !file_end;
            if (row_end) begin
                n_col = '0;
                n_row = file_end ? '0 : r_row + rgbb_pkg::CNT_W'(1);
            end else begin
                n_col = r_col + rgbb_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_hdr_done <= 1'b0;
        end else begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_hdr_done <= n_hdr_done;
        end
    end

endmodule

// ===== hw/rtl/rgbb_fifo.sv =====
// short command queue between front and back ends
module rgbb_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rgbb_pkg::t_cmd   i_cmd,
    input  logic             i_pop,
    output rgbb_pkg::t_cmd   o_cmd,
    output rgbb_pkg::t_qstat o_stat
);

    rgbb_pkg::t_cmd                r_mem [rgbb_pkg::Q_DEPTH];
    logic [rgbb_pkg::Q_AW-1:0]     r_wr;
    logic [rgbb_pkg::Q_AW-1:0]     r_rd;
    logic [rgbb_pkg::Q_AW:0]       r_level;
    logic [rgbb_pkg::Q_AW-1:0]     n_wr;
    logic [rgbb_pkg::Q_AW-1:0]     n_rd;
    logic [rgbb_pkg::Q_AW:0]       n_level;

    // status
    assign o_stat.empty = (r_level == '0);
    assign o_stat.full  = (r_level == (rgbb_pkg::Q_AW + 1)'(rgbb_pkg::Q_DEPTH));
    assign o_stat.level = r_level;
    assign o_cmd        = r_mem[r_rd];

    // pointer update, wrapping at depth
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_level = r_level;
        if (i_push) begin
            n_wr = (32'(r_wr) == rgbb_pkg::Q_DEPTH - 1) ? '0 : r_wr + rgbb_pkg::Q_AW'(1);
        end
        if (i_pop) begin
            n_rd = (32'(r_rd) == rgbb_pkg::Q_DEPTH - 1) ? '0 : r_rd + rgbb_pkg::Q_AW'(1);
        end
        if (i_push && !i_pop) begin
            n_level = r_level + (rgbb_pkg::Q_AW + 1)'(1);
        end else if (i_pop && !i_push) begin
            n_level = r_level - (rgbb_pkg::Q_AW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_level <= n_level;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== hw/rtl/rgbb_back.sv =====
// back end: byte sequencer for header, pixel and padding, with output register
module rgbb_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rgbb_pkg::t_cmd   i_cmd,
    input  logic             i_q_valid,
    output logic             o_pop,
    output logic             o_byte_valid,
    input  logic             i_byte_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_item,
    output logic             o_end_of_file
);

    rgbb_pkg::t_phase             r_phase;
    rgbb_pkg::t_phase             n_phase;
    rgbb_pkg::t_phase             cur_phase;
    logic [rgbb_pkg::HCNT_W-1:0]  r_cnt;
    logic [rgbb_pkg::HCNT_W-1:0]  n_cnt;
    logic                         r_valid;
    logic [7:0]                   r_byte;
    logic                         r_last;
    logic                         r_eof;
    logic [7:0]                   cur_byte;
    logic                         cur_last;
    logic                         load;
    logic                         step;
    logic [31:0]                  file_size;
    logic [31:0]                  img_size;
    logic [31:0]                  width32;
    logic [31:0]                  height32;

    // header byte at a given offset
    function automatic logic [7:0] hdr_byte(
        input logic [rgbb_pkg::HCNT_W-1:0] idx,
        input logic [31:0] fsize,
        input logic [31:0] wid,
        input logic [31:0] hgt,
        input logic [31:0] isize
    );
        begin
            case (idx)
                6'd0:    hdr_byte = rgbb_pkg::CHAR_B;
                6'd1:    hdr_byte = rgbb_pkg::CHAR_M;
                6'd2:    hdr_byte = fsize[7:0];
                6'd3:    hdr_byte = fsize[15:8];
                6'd4:    hdr_byte = fsize[23:16];
                6'd5:    hdr_byte = fsize[31:24];
                6'd10:   hdr_byte = 8'(rgbb_pkg::HDR_BYTES);
                6'd14:   hdr_byte = rgbb_pkg::HDR_INFO_SIZE;
                6'd18:   hdr_byte = wid[7:0];
                6'd19:   hdr_byte = wid[15:8];
                6'd20:   hdr_byte = wid[23:16];
                6'd21:   hdr_byte = wid[31:24];
                6'd22:   hdr_byte = hgt[7:0];
                6'd23:   hdr_byte = hgt[15:8];
                6'd24:   hdr_byte = hgt[23:16];
                6'd25:   hdr_byte = hgt[31:24];
                6'd26:   hdr_byte = rgbb_pkg::HDR_PLANES;
                6'd28:   hdr_byte = rgbb_pkg::HDR_BPP;
                6'd34:   hdr_byte = isize[7:0];
                6'd35:   hdr_byte = isize[15:8];
                6'd36:   hdr_byte = isize[23:16];
                6'd37:   hdr_byte = isize[31:24];
                default: hdr_byte = 8'd0;
            endcase
        end
    endfunction

    // header field values
    assign img_size  = 32'(i_cmd.img_size);
    assign file_size = img_size + 32'(rgbb_pkg::HDR_BYTES);
    assign width32   = 32'(i_cmd.width);
    assign height32  = 32'(i_cmd.height);

    // a word with no header starts straight at the pixel bytes
    assign cur_phase = (r_phase == rgbb_pkg::PH_HDR && !i_cmd.hdr) ? rgbb_pkg::PH_PIX
                                                                   : r_phase;

    assign load  = !r_valid || i_byte_ready;
    assign step  = i_q_valid && load;
    assign o_pop = step && cur_last;

    // byte and last flag for the current position
    always_comb begin
        cur_byte = 8'd0;
        cur_last = 1'b0;
        case (cur_phase)
            rgbb_pkg::PH_HDR: begin
                cur_byte = hdr_byte(r_cnt, file_size, width32, height32, img_size);
            end
            rgbb_pkg::PH_PIX: begin
                if (r_cnt == 6'd0) begin
                    cur_byte = i_cmd.blu;
                end else if (r_cnt == 6'd1) begin
                    cur_byte = i_cmd.grn;
                end else begin
                    cur_byte = i_cmd.red;
                end
                cur_last = (r_cnt == 6'd2) && (i_cmd.pad == 2'd0);
            end
            rgbb_pkg::PH_PAD: begin
                cur_last = (r_cnt[1:0] == i_cmd.pad - 2'd1);
            end
            default: begin
                cur_byte = 8'd0;
                cur_last = 1'b0;
            end
        endcase
    end

    // next phase and count
    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        if (step) begin
            case (cur_phase)
                rgbb_pkg::PH_HDR: begin
                    if (32'(r_cnt) == rgbb_pkg::HDR_BYTES - 1) begin
                        n_phase = rgbb_pkg::PH_PIX;
                        n_cnt   = '0;
                    end else begin
                        n_phase = rgbb_pkg::PH_HDR;
                        n_cnt   = r_cnt + rgbb_pkg::HCNT_W'(1);
                    end
                end
                rgbb_pkg::PH_PIX: begin
                    if (r_cnt == 6'd2) begin
                        n_phase = cur_last ? rgbb_pkg::PH_HDR : rgbb_pkg::PH_PAD;
                        n_cnt   = '0;
                    end else begin
                        n_phase = rgbb_pkg::PH_PIX;
                        n_cnt   = r_cnt + rgbb_pkg::HCNT_W'(1);
                    end
                end
                rgbb_pkg::PH_PAD: begin
                    if (cur_last) begin
                        n_phase = rgbb_pkg::PH_HDR;
                        n_cnt   = '0;
                    end else begin
                        n_phase = rgbb_pkg::PH_PAD;
                        n_cnt   = r_cnt + rgbb_pkg::HCNT_W'(1);
                    end
                end
                default: begin
                    n_phase = rgbb_pkg::PH_HDR;
                    n_cnt   = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= rgbb_pkg::PH_HDR;
            r_cnt   <= '0;
        end else begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (step) begin
            r_valid <= 1'b1;
        end else if (i_byte_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_byte <= cur_byte;
            r_last <= cur_last;
            r_eof  <= cur_last && i_cmd.eof;
        end
    end

    assign o_byte_valid   = r_valid;
    assign o_out_byte     = r_byte;
    assign o_last_of_item = r_last;
    assign o_end_of_file  = r_eof;

endmodule

// ===== hw/rtl/rgb565_to_bmp24_stream_top.sv =====
// top level of the rgb565 to 24-bit bmp byte stream encoder
//
// Pixel channel: i_pixel with i_pixel_valid / o_pixel_ready, one RGB565 word per
// pixel, rows bottom-first. Byte channel: o_out_byte with o_byte_valid /
// i_byte_ready, plus o_last_of_item on the final byte of a pixel and
// o_end_of_file on the final byte of the file. Image width and height are set
// through i_cfg_we / i_cfg_idx / i_cfg_data while the encoder is idle; 0 reads
// as 1 and values above 4096 as 4096.
// The first pixel of each file brings out the 54-byte header, then each pixel
// gives B, G, R and, at the end of a row, 0 to 3 zero pad bytes.
// An accepted pixel is written into the queue, and the back end loads its first
// byte into the output register when free. It gives one byte per cycle while
// the receiver is ready and the queue is not empty, set by the byte-wide output
// register: three bytes per pixel, 54 per header and 0 to 3 pad bytes per row.
// A two-word queue sits between the classifying front end and the byte
// sequencer, so pixels are taken while earlier bytes still wait.
// Reset (synchronous, active low) returns width 320, height 180 and rearms for
// a new header. When the receiver stalls the output byte holds, the queue
// fills and o_pixel_ready drops.
module rgb565_to_bmp24_stream_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rgbb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rgbb_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_pixel_valid,
    output logic                           o_pixel_ready,
    input  logic [15:0]                    i_pixel,
    output logic                           o_byte_valid,
    input  logic                           i_byte_ready,
    output logic [7:0]                     o_out_byte,
    output logic                           o_last_of_item,
    output logic                           o_end_of_file
);

    rgbb_pkg::t_cmd   push_cmd;
    rgbb_pkg::t_cmd   head_cmd;
    rgbb_pkg::t_qstat q_stat;
    logic             push;
    logic             pop;

    // front end
    rgbb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_pixel_valid (i_pixel_valid),
        .o_pixel_ready (o_pixel_ready),
        .i_pixel       (i_pixel),
        .i_q_full      (q_stat.full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    // command queue
    rgbb_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_stat  (q_stat)
    );

    // back end
    rgbb_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (head_cmd),
        .i_q_valid      (!q_stat.empty),
        .o_pop          (pop),
        .o_byte_valid   (o_byte_valid),
        .i_byte_ready   (i_byte_ready),
        .o_out_byte     (o_out_byte),
        .o_last_of_item (o_last_of_item),
        .o_end_of_file  (o_end_of_file)
    );

`ifndef SYNTHESIS
    // an accepted pixel is queued at the next edge
    a_push_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_pixel_valid && o_pixel_ready) |=> !q_stat.empty)
        else $error("accepted pixel not found in queue");

    // end of file only ever marks the last byte of a pixel
    a_eof_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_byte_valid && o_end_of_file) |-> o_last_of_item)
        else $error("end of file without last of pixel");

    // queue level only moves on push or pop
    a_level_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!push && !pop) |=> $stable(q_stat.level))
        else $error("queue level changed without push or pop");

    // pop only when the back end has a word
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule

// ===== tb/sv/bmp_stream_checker.sv =====
// checker for the bmp byte stream: predicts every byte of the file and compares
`timescale 1ns / 1ps

module bmp_stream_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rgbb_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [rgbb_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_pixel_valid,
    input  logic                           i_pixel_ready,
    input  logic [15:0]                    i_pixel,
    input  logic                           i_byte_valid,
    input  logic                           i_byte_ready,
    input  logic [7:0]                     i_out_byte,
    input  logic                           i_last_of_item,
    input  logic                           i_end_of_file,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_byte_count,
    output int                             o_file_count
);

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       eof;
    } t_bmp_byte;

    // bytes still owed by the encoder, oldest first
    t_bmp_byte        file_bytes_q[$];
    t_bmp_byte        want;

    // own copy of the size registers and the file position
    logic [rgbb_pkg::CFG_W-1:0] cur_width;
    logic [rgbb_pkg::CFG_W-1:0] cur_height;
    int unsigned      col_pos;
    int unsigned      rows_done;
    bit               header_sent;

    int               fails      = 0;
    int               bytes_seen = 0;
    int               files_seen = 0;

    // zero reads as one, oversize reads as the largest dimension
    function automatic int unsigned clamp_size(logic [rgbb_pkg::CFG_W-1:0] v);
        if (v == '0) return 1;
        if (v > rgbb_pkg::MAX_DIM) return rgbb_pkg::MAX_DIM;
        return int'(v);
    endfunction

    function automatic void push_byte(logic [7:0] data);
        t_bmp_byte item;
        item.data = data;
        item.last = 1'b0;
        item.eof  = 1'b0;
        file_bytes_q.push_back(item);
    endfunction

    // all bytes that one pixel word brings out
    function automatic void encode_pixel(logic [15:0] px);
        logic [7:0]  hdr [rgbb_pkg::HDR_BYTES];
        logic [31:0] word_val [6];
        int unsigned word_pos [6] = '{2, 10, 14, 18, 22, 34};
        int unsigned w;
        int unsigned h;
        int unsigned row_len;
        int unsigned pad_len;
        int unsigned img_len;
        int unsigned red5;
        int unsigned grn6;
        int unsigned blu5;
        bit          row_end;
        bit          file_end;
        t_bmp_byte   tail;

        w       = clamp_size(cur_width);
        h       = clamp_size(cur_height);
        row_len = (w * 3 + 3) & ~32'd3;
        pad_len = row_len - w * 3;
        img_len = row_len * h;

        // header ahead of the first pixel of a file
        if (!header_sent) begin
            foreach (hdr[k]) hdr[k] = 8'h00;
            hdr[0]      = rgbb_pkg::CHAR_B;
            hdr[1]      = rgbb_pkg::CHAR_M;
            word_val[0] = rgbb_pkg::HDR_BYTES + img_len;
            word_val[1] = rgbb_pkg::HDR_BYTES;
            word_val[2] = 32'(rgbb_pkg::HDR_INFO_SIZE);
            word_val[3] = w;
            word_val[4] = h;
            word_val[5] = img_len;
            for (int j = 0; j < 6; j++) begin
                for (int k = 0; k < 4; k++) begin
                    hdr[word_pos[j] + k] = word_val[j][8*k +: 8];
                end
            end
            hdr[26] = rgbb_pkg::HDR_PLANES;
            hdr[28] = rgbb_pkg::HDR_BPP;
            foreach (hdr[k]) push_byte(hdr[k]);
            header_sent = 1'b1;
        end

        // channel expansion, sent as b, g, r
        red5 = px[15:11];
        grn6 = px[10:5];
        blu5 = px[4:0];
        push_byte(8'(blu5 * 255 / 31));
        push_byte(8'(grn6 * 255 / 63));
        push_byte(8'(red5 * 255 / 31));

        // row and file bookkeeping against the live sizes
        row_end  = (col_pos + 1 >= w);
        file_end = row_end && (rows_done + 1 >= h);
        if (row_end) begin
            for (int k = 0; k < int'(pad_len); k++) push_byte(8'h00);
            col_pos = 0;
            if (file_end) begin
                rows_done   = 0;
                header_sent = 1'b0;
            end else begin
                rows_done = rows_done + 1;
            end
        end else begin
            col_pos = col_pos + 1;
        end

        tail      = file_bytes_q.pop_back();
        tail.last = 1'b1;
        tail.eof  = file_end;
        file_bytes_q.push_back(tail);
    endfunction

    // watch both channels and the register port
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cur_width   = rgbb_pkg::RST_IMAGE_WIDTH;
            cur_height  = rgbb_pkg::RST_IMAGE_HEIGHT;
            col_pos     = 0;
            rows_done   = 0;
            header_sent = 1'b0;
            file_bytes_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == rgbb_pkg::CFG_IMAGE_WIDTH) begin
                    cur_width = i_cfg_data;
                end else if (i_cfg_idx == rgbb_pkg::CFG_IMAGE_HEIGHT) begin
                    cur_height = i_cfg_data;
                end
            end

            if (i_pixel_valid && i_pixel_ready) begin
                encode_pixel(i_pixel);
            end

            // compare each byte word with the oldest prediction
            if (i_byte_valid && i_byte_ready) begin
                if (file_bytes_q.size() == 0) begin
                    $error("unexpected byte word: out_byte %0h last_of_item %0b end_of_file %0b",
                           i_out_byte, i_last_of_item, i_end_of_file);
                    fails++;
                end else begin
                    want = file_bytes_q.pop_front();
                    bytes_seen++;
                    if (want.eof) files_seen++;
                    if (i_out_byte !== want.data) begin
                        $error("out_byte mismatch: expected %0h, actual %0h",
                               want.data, i_out_byte);
                        fails++;
                    end
                    if (i_last_of_item !== want.last) begin
                        $error("last_of_item mismatch: expected %0b, actual %0b",
                               want.last, i_last_of_item);
                        fails++;
                    end
                    if (i_end_of_file !== want.eof) begin
                        $error("end_of_file mismatch: expected %0b, actual %0b",
                               want.eof, i_end_of_file);
                        fails++;
                    end
                end
            end
        end

        o_fail_count <= fails;
        o_pending    <= file_bytes_q.size();
        o_byte_count <= bytes_seen;
        o_file_count <= files_seen;
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// top of the bmp stream encoder testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

    typedef enum {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH,
        IDLE_HOLD
    } t_idle_mode;

    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int TAIL_CYCLES  = 8;
    localparam int RANDOM_ITEMS = 150;

    logic                           i_clk          = 1'b0;
    logic                           i_rst_n        = 1'b0;
    logic                           i_cfg_we       = 1'b0;
    logic [rgbb_pkg::CFG_IDX_W-1:0] i_cfg_idx      = rgbb_pkg::CFG_IMAGE_WIDTH;
    logic [rgbb_pkg::CFG_W-1:0]     i_cfg_data     = '0;
    logic                           i_pixel_valid  = 1'b0;
    logic                           o_pixel_ready;
    logic [15:0]                    i_pixel        = '0;
    logic                           o_byte_valid;
    logic                           i_byte_ready   = 1'b0;
    logic [7:0]                     o_out_byte;
    logic                           o_last_of_item;
    logic                           o_end_of_file;

    int                   fail_count;
    int                   pending;
    int                   byte_count;
    int                   file_count;

    t_idle_mode           idle_mode = IDLE_NONE;
    int                   pixels_sent = 0;
    int                   sizes_used = 0;
    int                   quiet_cycles = 0;

    logic [15:0] directed_px [8] = '{16'h0000, 16'hFFFF, 16'hF800, 16'h07E0,
                                     16'h001F, 16'h0821, 16'h8410, 16'h7BEF};

    // clock
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    rgb565_to_bmp24_stream_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_pixel_valid  (i_pixel_valid),
        .o_pixel_ready  (o_pixel_ready),
        .i_pixel        (i_pixel),
        .o_byte_valid   (o_byte_valid),
        .i_byte_ready   (i_byte_ready),
        .o_out_byte     (o_out_byte),
        .o_last_of_item (o_last_of_item),
        .o_end_of_file  (o_end_of_file)
    );

    bmp_stream_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_pixel_valid  (i_pixel_valid),
        .i_pixel_ready  (o_pixel_ready),
        .i_pixel        (i_pixel),
        .i_byte_valid   (o_byte_valid),
        .i_byte_ready   (i_byte_ready),
        .i_out_byte     (o_out_byte),
        .i_last_of_item (o_last_of_item),
        .i_end_of_file  (o_end_of_file),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_byte_count   (byte_count),
        .o_file_count   (file_count)
    );

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    // mostly random pixels, some all-zero and all-one words
    function automatic logic [15:0] pick_pixel();
        if (chance(12)) return chance(50) ? 16'h0000 : 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    // receiver: random stalls, or one long hold-off on entry to the hold mode
    initial begin
        int         hold_left;
        int         stall_pct;
        t_idle_mode prev_mode;
        hold_left = 0;
        prev_mode = IDLE_NONE;
        forever begin
            @(posedge i_clk);
            if (idle_mode == IDLE_HOLD && prev_mode != IDLE_HOLD) hold_left = HOLD_CYCLES;
            prev_mode = idle_mode;
            case (idle_mode)
                IDLE_RECV: stall_pct = 54;
                IDLE_BOTH: stall_pct = 32;
                default:   stall_pct = 0;
            endcase
            if (hold_left > 0) begin
                hold_left--;
                i_byte_ready <= 1'b0;
            end else begin
                i_byte_ready <= !chance(stall_pct);
            end
        end
    end

    // offer one pixel word, with random gaps ahead of it
    task automatic send_pixel(input logic [15:0] px);
        int gap_pct;
        case (idle_mode)
            IDLE_SEND: gap_pct = 54;
            IDLE_BOTH: gap_pct = 32;
            default:   gap_pct = 0;
        endcase
        while (chance(gap_pct)) begin
            i_pixel_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_pixel_valid <= 1'b1;
        i_pixel       <= px;
        do @(posedge i_clk); while (!o_pixel_ready);
        pixels_sent++;
    endtask

    // stop offering and wait until every predicted byte has come out
    task automatic drain();
        i_pixel_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // new image size, written only with the encoder idle
    task automatic set_size(input logic [rgbb_pkg::CFG_W-1:0] w,
                            input logic [rgbb_pkg::CFG_W-1:0] h);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= rgbb_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx  <= rgbb_pkg::CFG_IMAGE_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sizes_used++;
    endtask

    // watchdog on cycles with no word moving on either channel
    always @(posedge i_clk) begin
        if ((i_pixel_valid && o_pixel_ready) || (o_byte_valid && i_byte_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("[rgb565_to_bmp24_stream_top] ERROR");
            $finish;
        end
    end

    // stimulus
    initial begin
        int                         random_sent;
        int                         phase;
        int                         count;
        logic [rgbb_pkg::CFG_W-1:0] w;
        logic [rgbb_pkg::CFG_W-1:0] h;
        logic [rgbb_pkg::CFG_W-1:0] extremes [4];

        extremes    = '{13'd0, 13'd4095, 13'd4096, 13'h1FFF};
        random_sent = 0;
        phase       = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: channel extremes at the reset size
        idle_mode = IDLE_NONE;
        foreach (directed_px[k]) send_pixel(directed_px[k]);

        // one-pixel files, largest result count per word
        set_size(13'd1, 13'd1);
        send_pixel(16'hFFFF);
        send_pixel(16'h0000);
        send_pixel(16'hA5A5);

        // zero sizes read as one
        set_size(13'd0, 13'd0);
        send_pixel(16'h1234);
        send_pixel(16'hEDCB);

        // row padding of two, three and zero bytes
        set_size(13'd2, 13'd2);
        repeat (4) send_pixel(pick_pixel());
        set_size(13'd3, 13'd1);
        repeat (3) send_pixel(pick_pixel());
        set_size(13'd4, 13'd1);
        repeat (4) send_pixel(pick_pixel());

        // oversize clamps; the file stays open into the next size
        set_size(13'h1FFF, 13'h1FFF);
        send_pixel(pick_pixel());

        // random phases cycling through the idle modes, one long hold-off
        while (random_sent < RANDOM_ITEMS) begin
            w = 13'($urandom_range(1, 6));
            h = 13'($urandom_range(1, 4));
            if (chance(15)) w = extremes[$urandom_range(0, 3)];
            if (chance(15)) h = extremes[$urandom_range(0, 3)];
            set_size(w, h);
            idle_mode = (phase == 5) ? IDLE_HOLD : t_idle_mode'(phase % 4);
            count = $urandom_range(10, 20);
            repeat (count) send_pixel(pick_pixel());
            random_sent += count;
            phase++;
        end

        drain();

        $display("covered %0d pixel words over %0d image sizes: %0d bytes checked, %0d files",
                 pixels_sent, sizes_used, byte_count, file_count);
        $display("idle modes: none, sender gaps, receiver stalls, both, long receiver hold-off");
        if (fail_count == 0 && pending == 0) begin
            $display("[rgb565_to_bmp24_stream_top] OK");
        end else begin
            $display("[rgb565_to_bmp24_stream_top] ERROR");
        end
        $finish;
    end

endmodule
